// File: design/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg: shared definitions for the error diffusion dither
// Types, register codes, reset values and the weighted share add.
// ----------------------------------------------------------------------------
package edd_pkg;

  // default line buffer depth (pixels per row at most)
  localparam int MAX_WIDTH_DEF = 1024;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_DOWN_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_DOWN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_DOWN_RIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATE_ENABLE   = 3'd5;

  // register reset values
  localparam logic [10:0] RST_IMAGE_WIDTH       = 11'd640;
  localparam logic [4:0]  RST_WEIGHT_RIGHT      = 5'd7;
  localparam logic [4:0]  RST_WEIGHT_DOWN_LEFT  = 5'd3;
  localparam logic [4:0]  RST_WEIGHT_DOWN       = 5'd5;
  localparam logic [4:0]  RST_WEIGHT_DOWN_RIGHT = 5'd1;
  localparam logic        RST_SATURATE_ENABLE   = 1'b1;

  // threshold and white level
  localparam logic [7:0] THRESHOLD   = 8'd128;
  localparam logic [8:0] WHITE_LEVEL = 9'd255;

  typedef logic [7:0]        pix_t;
  typedef logic [4:0]        weight_t;
  typedef logic signed [8:0] err_t;   // quantization error, -126..+128

  // value + err*wt/16, cut to a whole number, then saturated or wrapped
  function automatic pix_t add_share(input pix_t value, input err_t err,
                                     input weight_t wt, input logic sat);
    logic signed [14:0] prod;
    logic signed [14:0] sum;
    logic signed [14:0] rnd;
    logic signed [14:0] quo;
    pix_t               res;
    prod = 15'(err) * $signed({10'b0, wt});
    sum  = $signed({3'b000, value, 4'b0000}) + prod;
    if (sat) begin
      quo = sum >>> 4;
      if (sum < 0) begin
        res = 8'd0;
      end else if (quo > 15'sd255) begin
        res = 8'd255;
      end else begin
        res = quo[7:0];
      end
    end else begin
      // truncate toward zero: bias negatives before the shift
      rnd = (sum < 0) ? (sum + 15'sd15) : sum;
      quo = rnd >>> 4;
      res = quo[7:0];
    end
    return res;
  endfunction

endpackage

// File: design/edd_stream_if.sv
// ----------------------------------------------------------------------------
// edd_stream_if: pixel stream channels
// Input channel carries gray pixels, output channel carries dithered bits.
// ----------------------------------------------------------------------------
interface edd_pix_if;
  logic          valid;
  logic          ready;
  edd_pkg::pix_t gray_value;
  logic          frame_start;

  modport source (output valid, output gray_value, output frame_start, input ready);
  modport sink   (input valid, input gray_value, input frame_start, output ready);
endinterface

interface edd_bit_if;
  logic valid;
  logic ready;
  logic is_white;
  logic row_end;

  modport source (output valid, output is_white, output row_end, input ready);
  modport sink   (input valid, input is_white, input row_end, output ready);
endinterface

// File: design/edd_line_buf.sv
// ----------------------------------------------------------------------------
// edd_line_buf: error line memory
// Two registered read ports, one write port. A read that lands on the
// entry written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module edd_line_buf #(
  parameter int DEPTH = edd_pkg::MAX_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           ren,
  input  logic [AW-1:0]  raddr_a,
  input  logic [AW-1:0]  raddr_b,
  input  logic           wen,
  input  logic [AW-1:0]  waddr,
  input  edd_pkg::err_t  wdata,
  output edd_pkg::err_t  rdata_a,
  output edd_pkg::err_t  rdata_b
);

  edd_pkg::err_t mem [DEPTH];
  edd_pkg::err_t mem_q_a;
  edd_pkg::err_t mem_q_b;
  edd_pkg::err_t fwd_data;
  logic          fwd_a;
  logic          fwd_b;

  // storage: write port and two read ports
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      mem_q_a  <= mem[raddr_a];
      mem_q_b  <= mem[raddr_b];
      fwd_data <= wdata;
    end
  end

  // read-during-write bypass flags
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_a <= 1'b0;
      fwd_b <= 1'b0;
    end else if (ren) begin
      fwd_a <= wen && (waddr == raddr_a);
      fwd_b <= wen && (waddr == raddr_b);
    end
  end

  assign rdata_a = fwd_a ? fwd_data : mem_q_a;
  assign rdata_b = fwd_b ? fwd_data : mem_q_b;

endmodule

// File: design/error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither: streaming error diffusion dither
// Gray pixels in raster order in, one black/white bit per pixel out.
//
//   channel   dir  payload                    note
//   pix_in    in   gray_value, frame_start    one beat per pixel
//   pix_out   out  is_white, row_end          one beat per pixel
//   cfg       in   cfg_wr_en/index/data       write only, while idle
//
// One pixel per clock sustained while pix_out is ready. A beat taken on pix_in
// passes the compute stage, then the output register. The two-port error line read
// sits in the accept cycle; the four-share chain and write-back sit in compute.
// Reset: synchronous, clears control state; the line memory is not cleared.
// A stall on pix_out holds the compute stage; pix_in then stops taking beats.
// ----------------------------------------------------------------------------
module error_diffusion_dither #(
  parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [edd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [edd_pkg::CFG_DATA_W-1:0] cfg_data,
  edd_pix_if.sink                        pix_in,
  edd_bit_if.source                      pix_out
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WW > 11) ? WW : 11;

  // configuration registers
  logic [10:0]      image_width;
  edd_pkg::weight_t weight_right;
  edd_pkg::weight_t weight_down_left;
  edd_pkg::weight_t weight_down;
  edd_pkg::weight_t weight_down_right;
  logic             saturate_enable;

  // row tracking
  logic [AW-1:0] col;
  logic          first_row;

  // compute stage
  logic          s1_valid;
  logic [AW-1:0] s1_x;
  logic          s1_last;
  logic          s1_first;
  edd_pkg::pix_t s1_gray;

  // loop-carried errors
  edd_pkg::err_t left_error;
  edd_pkg::err_t prev_above;

  // output register
  logic out_valid;
  logic out_white;
  logic out_row_end;

  logic          acc;
  logic          s1_fire;
  logic [AW-1:0] s0_x;
  logic          s0_first;
  logic          s0_last;
  logic [CW-1:0] wid_raw;
  logic [CW-1:0] wid_eff;
  logic [CW-1:0] x_inc;
  edd_pkg::err_t rd_up;
  edd_pkg::err_t rd_up_right;
  edd_pkg::err_t above;
  edd_pkg::pix_t v;
  logic          white;
  edd_pkg::err_t err;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= edd_pkg::RST_IMAGE_WIDTH;
      weight_right      <= edd_pkg::RST_WEIGHT_RIGHT;
      weight_down_left  <= edd_pkg::RST_WEIGHT_DOWN_LEFT;
      weight_down       <= edd_pkg::RST_WEIGHT_DOWN;
      weight_down_right <= edd_pkg::RST_WEIGHT_DOWN_RIGHT;
      saturate_enable   <= edd_pkg::RST_SATURATE_ENABLE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        edd_pkg::CFG_IMAGE_WIDTH:       image_width       <= cfg_data;
        edd_pkg::CFG_WEIGHT_RIGHT:      weight_right      <= cfg_data[4:0];
        edd_pkg::CFG_WEIGHT_DOWN_LEFT:  weight_down_left  <= cfg_data[4:0];
        edd_pkg::CFG_WEIGHT_DOWN:       weight_down       <= cfg_data[4:0];
        edd_pkg::CFG_WEIGHT_DOWN_RIGHT: weight_down_right <= cfg_data[4:0];
        edd_pkg::CFG_SATURATE_ENABLE:   saturate_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_fire      = s1_valid && (!out_valid || pix_out.ready);
  assign pix_in.ready = !s1_valid || s1_fire;
  assign acc          = pix_in.valid && pix_in.ready;

  // accept stage: column, row flags, effective width
  assign wid_raw  = CW'(image_width);
  assign wid_eff  = (wid_raw == '0) ? CW'(1) :
                    (wid_raw > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : wid_raw;
  assign s0_x     = pix_in.frame_start ? '0 : col;
  assign s0_first = pix_in.frame_start ? 1'b1 : first_row;
  assign x_inc    = CW'(s0_x) + CW'(1);
  assign s0_last  = (x_inc >= wid_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      first_row <= 1'b1;
    end else if (acc) begin
      col       <= s0_last ? '0 : AW'(x_inc);
      first_row <= s0_first && !s0_last;
    end
  end

  // error line: up and up-right entries read on accept
  edd_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line (
    .clk     (clk),
    .rst     (rst),
    .ren     (acc),
    .raddr_a (s0_x),
    .raddr_b (AW'(x_inc)),
    .wen     (s1_fire),
    .waddr   (s1_x),
    .wdata   (err),
    .rdata_a (rd_up),
    .rdata_b (rd_up_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_x     <= s0_x;
      s1_last  <= s0_last;
      s1_first <= s0_first;
      s1_gray  <= pix_in.gray_value;
    end
  end

  // share chain: up-left, up, up-right, left; then threshold
  always_comb begin
    above = s1_first ? '0 : rd_up;
    v     = s1_gray;
    if (!s1_first) begin
      if (s1_x != '0) begin
        v = edd_pkg::add_share(v, prev_above, weight_down_right, saturate_enable);
      end
      v = edd_pkg::add_share(v, rd_up, weight_down, saturate_enable);
      if (!s1_last) begin
        v = edd_pkg::add_share(v, rd_up_right, weight_down_left, saturate_enable);
      end
    end
    if (s1_x != '0) begin
      v = edd_pkg::add_share(v, left_error, weight_right, saturate_enable);
    end
    white = (v > edd_pkg::THRESHOLD);
    err   = white ? $signed({1'b0, v} - edd_pkg::WHITE_LEVEL) : $signed({1'b0, v});
  end

  // loop-carried errors update as the pixel leaves the compute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      left_error <= '0;
      prev_above <= '0;
    end else if (s1_fire) begin
      left_error <= s1_last ? '0 : err;
      prev_above <= s1_last ? '0 : above;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_white   <= white;
      out_row_end <= s1_last;
    end
  end

  assign pix_out.valid    = out_valid;
  assign pix_out.is_white = out_white;
  assign pix_out.row_end  = out_row_end;

`ifndef SYNTHESIS
  // a pixel leaving compute always lands in the output register
  a_fire_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("compute result not registered at output");

  // a stalled compute stage keeps its pixel
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |=> (s1_valid && $stable(s1_x) && $stable(s1_last)))
    else $error("compute stage lost its pixel while stalled");

  // the last pixel of a row returns the column to zero and ends the first row
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc && s0_last) |=> (col == '0 && !first_row))
    else $error("row wrap did not reset column");

  // inside a row the column steps by one
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    (acc && !s0_last) |=> (col == $past(AW'(x_inc))))
    else $error("column did not advance");
`endif

endmodule
